// ----- hw/rtl/clt_pkg.sv -----
// Shared types, keyword table and helper functions for the control language tokenizer.
`default_nettype none
package clt_pkg;

  localparam int unsigned NUM_KW = 11;
  localparam int unsigned Q_DEPTH = 3;
  localparam logic [7:0] MAX_WORD_LEN = 8'd255;
  localparam logic [15:0] MAX_POS = 16'hFFFF;

  // Token kinds
  localparam logic [4:0] KIND_COLON = 5'd0;
  localparam logic [4:0] KIND_NOTEQ = 5'd1;
  localparam logic [4:0] KIND_GT = 5'd2;
  localparam logic [4:0] KIND_LT = 5'd3;
  localparam logic [4:0] KIND_AND = 5'd4;
  localparam logic [4:0] KIND_OR = 5'd5;
  localparam logic [4:0] KIND_EQEQ = 5'd6;
  localparam logic [4:0] KIND_EQ = 5'd7;
  localparam logic [4:0] KIND_SEMI = 5'd8;
  localparam logic [4:0] KIND_VAR = 5'd9;
  localparam logic [4:0] KIND_OBJECT = 5'd10;
  localparam logic [4:0] KIND_TYPE = 5'd11;
  localparam logic [4:0] KIND_IF = 5'd12;
  localparam logic [4:0] KIND_THEN = 5'd13;
  localparam logic [4:0] KIND_ENDIF = 5'd14;
  localparam logic [4:0] KIND_BOOL = 5'd15;
  localparam logic [4:0] KIND_FLOAT = 5'd16;
  localparam logic [4:0] KIND_INT = 5'd17;
  localparam logic [4:0] KIND_IDENT = 5'd18;

  // Pending operator codes
  localparam logic [2:0] PEND_NONE = 3'd0;
  localparam logic [2:0] PEND_BANG = 3'd1;
  localparam logic [2:0] PEND_AMP = 3'd2;
  localparam logic [2:0] PEND_BAR = 3'd3;
  localparam logic [2:0] PEND_EQ = 3'd4;

  // Characters of interest
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_LT = 8'h3C;
  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_AMP = 8'h26;
  localparam logic [7:0] CH_BAR = 8'h7C;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;

  // Keyword table, text left aligned and padded to six characters
  localparam logic [47:0] KW_STR [NUM_KW] = '{
    "VAR   ", "MOTOR ", "VALVE ", "INT   ", "FLOAT ", "BOOL  ",
    "IF    ", "THEN  ", "END_IF", "true  ", "false "
  };
  localparam logic [7:0] KW_LEN [NUM_KW] = '{
    8'd3, 8'd5, 8'd5, 8'd3, 8'd5, 8'd4, 8'd2, 8'd4, 8'd6, 8'd4, 8'd5
  };
  localparam logic [4:0] KW_KIND [NUM_KW] = '{
    KIND_VAR, KIND_OBJECT, KIND_OBJECT, KIND_TYPE, KIND_TYPE, KIND_TYPE,
    KIND_IF, KIND_THEN, KIND_ENDIF, KIND_BOOL, KIND_BOOL
  };
  localparam logic [1:0] KW_VARIANT [NUM_KW] = '{
    2'd0, 2'd0, 2'd1, 2'd0, 2'd1, 2'd2, 2'd0, 2'd0, 2'd0, 2'd1, 2'd0
  };

  typedef struct packed {
    logic              in_word;
    logic [15:0]       start;
    logic [7:0]        length;
    logic              overflow;
    logic [NUM_KW-1:0] cand;
    logic              all_digits;
    logic              has_dot;
  } word_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [1:0]  variant;
    logic [15:0] start;
    logic [7:0]  length;
    logic        too_long;
    logic        last;
  } result_t;

  // Character i of keyword k
  function automatic logic [7:0] kw_byte(int k, logic [2:0] i);
    logic [7:0] b;
    b = 8'h00;
    if (i <= 3'd5) begin
      b = KW_STR[k][8*(5-int'(i)) +: 8];
    end
    return b;
  endfunction

  function automatic result_t mk_res(logic [4:0] kind, logic [15:0] start,
                                     logic [7:0] length);
    result_t r;
    r = '0;
    r.kind = kind;
    r.start = start;
    r.length = length;
    return r;
  endfunction

  // Reset the word trackers, keeping the start position
  function automatic word_t word_clear(word_t w);
    word_t r;
    r = w;
    r.in_word = 1'b0;
    r.length = 8'd0;
    r.overflow = 1'b0;
    r.cand = '1;
    r.all_digits = 1'b1;
    r.has_dot = 1'b0;
    return r;
  endfunction

  // Append one byte to the open word
  function automatic word_t add_char(word_t w, logic [7:0] c);
    word_t r;
    r = w;
    if (w.length >= MAX_WORD_LEN) begin
      r.overflow = 1'b1;
      r.cand = '0;
    end else begin
      for (int k = 0; k < NUM_KW; k++) begin
        if (w.length >= KW_LEN[k] || kw_byte(k, w.length[2:0]) != c) begin
          r.cand[k] = 1'b0;
        end
      end
      r.length = w.length + 8'd1;
    end
    if (c < CH_0 || c > CH_9) begin
      r.all_digits = 1'b0;
    end
    if (c == CH_DOT) begin
      r.has_dot = 1'b1;
    end
    return r;
  endfunction

  // Classify a finished word; the lowest matching keyword wins
  function automatic result_t word_res(word_t w);
    result_t r;
    r = mk_res(KIND_IDENT, w.start, w.length);
    r.too_long = w.overflow;
    if (w.has_dot) begin
      r.kind = KIND_FLOAT;
    end else if (w.all_digits) begin
      r.kind = KIND_INT;
    end
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (w.cand[k] && !w.overflow && w.length == KW_LEN[k]) begin
        r.kind = KW_KIND[k];
        r.variant = KW_VARIANT[k];
      end
    end
    return r;
  endfunction

  function automatic logic is_term(logic [7:0] c);
    return c == CH_SP || c == CH_SEMI || c == CH_COLON || c == CH_EQ ||
           c == CH_LT || c == CH_GT || c == CH_BANG;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/control_language_tokenizer.sv -----
// Top level of the control language tokenizer: byte decode, word state and result queue.
`default_nettype none
// Takes one source byte per beat (tlast marks the final byte of a text) and emits tokens
// with kind, variant, start position and length. A byte is taken every cycle while the
// three-entry result queue holds at most one token; a byte that yields two tokens (word
// or lone '=' followed by an operator, or end of text closing a word) raises the queue to
// two or three entries, so with the output draining one token per cycle the input pauses
// until the queue is back to one token. Decode is single pass: the input beat and the word state feed
// one level of logic that writes the queue and updates the state in the same cycle.
// Position saturates at 65535 and returns to 0 after the last byte of a text; word
// lengths saturate at 255 with too_long set.
module control_language_tokenizer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] byte_in
  input  wire logic        in_tlast,   // end_of_text
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [15:0] text_start, [23:16] text_length
  output logic [7:0]       out_tuser,  // [4:0] token_kind, [6:5] variant, [7] too_long
  output logic             out_tlast   // last_of_run
);
  import clt_pkg::*;

  logic [15:0] pos_r, pos_nxt;
  logic [2:0]  pend_r, pend_nxt;
  word_t       word_r, word_nxt;
  result_t     q_r [Q_DEPTH];
  result_t     q_nxt [Q_DEPTH];
  logic [1:0]  q_cnt_r, q_cnt_nxt;

  logic        accept, pop;
  result_t     res [2];
  logic [1:0]  n_new;
  logic [1:0]  base;
  logic        consumed, go;

  assign in_tready  = (q_cnt_r <= 2'd1);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = (q_cnt_r != 2'd0);
  assign pop        = out_tvalid && out_tready;

  // Decode one byte against the pending operator and open word
  always_comb begin
    word_nxt = word_r;
    pend_nxt = PEND_NONE;
    res[0]   = '0;
    res[1]   = '0;
    n_new    = 2'd0;
    consumed = 1'b0;
    go       = 1'b1;

    priority if (pend_r == PEND_BANG && in_tdata == CH_EQ) begin
      res[0] = mk_res(KIND_NOTEQ, word_r.start, 8'd2);
      n_new = 2'd1;
      consumed = 1'b1;
    end else if (pend_r == PEND_AMP && in_tdata == CH_AMP) begin
      res[0] = mk_res(KIND_AND, word_r.start, 8'd2);
      n_new = 2'd1;
      consumed = 1'b1;
    end else if (pend_r == PEND_BAR && in_tdata == CH_BAR) begin
      res[0] = mk_res(KIND_OR, word_r.start, 8'd2);
      n_new = 2'd1;
      consumed = 1'b1;
    end else if (pend_r == PEND_EQ && in_tdata == CH_EQ) begin
      res[0] = mk_res(KIND_EQEQ, word_r.start, 8'd2);
      n_new = 2'd1;
      consumed = 1'b1;
    end else if (pend_r == PEND_EQ) begin
      res[0] = mk_res(KIND_EQ, word_r.start, 8'd1);
      n_new = 2'd1;
    end else begin
    end

    if (!consumed) begin
      // Close or extend an open word
      if (word_nxt.in_word) begin
        if (is_term(in_tdata)) begin
          res[n_new[0]] = word_res(word_nxt);
          n_new = n_new + 2'd1;
          word_nxt = word_clear(word_nxt);
        end else begin
          word_nxt = add_char(word_nxt, in_tdata);
          go = 1'b0;
        end
      end
      if (go) begin
        unique case (in_tdata)
          CH_SP, CH_TAB, CH_CR, CH_LF: begin
          end
          CH_COLON: begin
            res[n_new[0]] = mk_res(KIND_COLON, pos_r, 8'd1);
            n_new = n_new + 2'd1;
          end
          CH_GT: begin
            res[n_new[0]] = mk_res(KIND_GT, pos_r, 8'd1);
            n_new = n_new + 2'd1;
          end
          CH_LT: begin
            res[n_new[0]] = mk_res(KIND_LT, pos_r, 8'd1);
            n_new = n_new + 2'd1;
          end
          CH_SEMI: begin
            res[n_new[0]] = mk_res(KIND_SEMI, pos_r, 8'd1);
            n_new = n_new + 2'd1;
          end
          CH_BANG: begin
            pend_nxt = PEND_BANG;
            word_nxt.start = pos_r;
          end
          CH_AMP: begin
            pend_nxt = PEND_AMP;
            word_nxt.start = pos_r;
          end
          CH_BAR: begin
            pend_nxt = PEND_BAR;
            word_nxt.start = pos_r;
          end
          CH_EQ: begin
            pend_nxt = PEND_EQ;
            word_nxt.start = pos_r;
          end
          default: begin
            word_nxt = word_clear(word_nxt);
            word_nxt.in_word = 1'b1;
            word_nxt.start = pos_r;
            word_nxt = add_char(word_nxt, in_tdata);
          end
        endcase
      end
    end

    pos_nxt = (pos_r == MAX_POS) ? pos_r : pos_r + 16'd1;

    // Flush at end of text
    if (in_tlast) begin
      if (word_nxt.in_word) begin
        res[n_new[0]] = word_res(word_nxt);
        n_new = n_new + 2'd1;
        word_nxt = word_clear(word_nxt);
      end
      if (pend_nxt == PEND_EQ) begin
        res[n_new[0]] = mk_res(KIND_EQ, word_nxt.start, 8'd1);
        n_new = n_new + 2'd1;
      end
      pend_nxt = PEND_NONE;
      pos_nxt = 16'd0;
    end

    // Mark the final token of this byte
    if (n_new != 2'd0) begin
      res[n_new[1]].last = 1'b1;
    end
  end

  // Shift out the head and append new tokens behind the survivors
  assign base = q_cnt_r - {1'b0, pop};

  always_comb begin
    for (int i = 0; i < Q_DEPTH; i++) begin
      if (pop && i < Q_DEPTH - 1) begin
        q_nxt[i] = q_r[i+1];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if (accept && n_new != 2'd0 && 2'(i) == base) begin
        q_nxt[i] = res[0];
      end
      if (accept && n_new == 2'd2 && 2'(i) == base + 2'd1) begin
        q_nxt[i] = res[1];
      end
    end
    q_cnt_nxt = base + (accept ? n_new : 2'd0);
  end

  // Hold state and queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 16'd0;
      pend_r  <= PEND_NONE;
      word_r  <= word_clear('0);
      q_cnt_r <= 2'd0;
    end else begin
      if (accept) begin
        pos_r  <= pos_nxt;
        pend_r <= pend_nxt;
        word_r <= word_nxt;
      end
      q_cnt_r <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < Q_DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  // Drive the output beat from the queue head
  assign out_tdata = {q_r[0].length, q_r[0].start};
  assign out_tuser = {q_r[0].too_long, q_r[0].variant, q_r[0].kind};
  assign out_tlast = q_r[0].last;

  // An open word never coexists with a pending operator
  a_word_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    word_r.in_word |-> pend_r == PEND_NONE)
    else $error("pending operator while a word is open");

  // End of text leaves a fresh text state
  a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tlast |=> pos_r == 16'd0 && pend_r == PEND_NONE && !word_r.in_word)
    else $error("state not cleared after end of text");

  // A byte yielding two tokens leaves at least two queued
  a_two_tokens: assert property (@(posedge clk) disable iff (!rst_n)
    accept && n_new == 2'd2 |=> q_cnt_r >= 2'd2)
    else $error("token lost from result queue");

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the control language tokenizer: byte stream in, token stream out.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import clt_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_BYTES = 630;
  localparam int TAIL_CYCLES = 20;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [4:0]  kind;
    logic [1:0]  variant;
    logic [15:0] start;
    logic [7:0]  length;
    logic        too_long;
    logic        last;
  } token_t;

  typedef struct {
    logic [7:0] c;
    logic       last;
  } src_byte_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_STINGY} rx_mode_t;

  // Tracks the tokenizer state and holds the tokens still owed by the block
  class token_tracker;
    token_t            tokens_due[$];
    token_t            step_tokens[$];
    int                errors;
    logic [15:0]       pos;
    logic [2:0]        pend;
    logic              in_word;
    logic [15:0]       wstart;
    logic [7:0]        wlen;
    logic              wovf;
    logic [NUM_KW-1:0] cand;
    logic              digits;
    logic              dot;
    string             kw_text[NUM_KW];
    logic [4:0]        kw_kind[NUM_KW];
    logic [1:0]        kw_var[NUM_KW];

    function new();
      kw_text = '{"VAR", "MOTOR", "VALVE", "INT", "FLOAT", "BOOL",
                  "IF", "THEN", "END_IF", "true", "false"};
      kw_kind = '{KIND_VAR, KIND_OBJECT, KIND_OBJECT, KIND_TYPE, KIND_TYPE, KIND_TYPE,
                  KIND_IF, KIND_THEN, KIND_ENDIF, KIND_BOOL, KIND_BOOL};
      kw_var = '{2'd0, 2'd0, 2'd1, 2'd0, 2'd1, 2'd2, 2'd0, 2'd0, 2'd0, 2'd1, 2'd0};
      errors = 0;
      pos = '0;
      pend = PEND_NONE;
      wstart = '0;
      restart_word();
    endfunction

    function void restart_word();
      in_word = 1'b0;
      wlen = '0;
      wovf = 1'b0;
      cand = '1;
      digits = 1'b1;
      dot = 1'b0;
    endfunction

    function void push(logic [4:0] kind, logic [1:0] variant, logic [15:0] start,
                       logic [7:0] len, logic long_word);
      token_t t;
      t.kind = kind;
      t.variant = variant;
      t.start = start;
      t.length = len;
      t.too_long = long_word;
      t.last = 1'b0;
      step_tokens.insert(step_tokens.size(), t);
    endfunction

    // Narrow the keyword candidates and update the digit and dot flags
    function void grow_word(logic [7:0] c);
      if (wlen >= MAX_WORD_LEN) begin
        wovf = 1'b1;
        cand = '0;
      end else begin
        for (int k = 0; k < NUM_KW; k++) begin
          if (cand[k] && (int'(wlen) >= kw_text[k].len() ||
                          kw_text[k][int'(wlen)] != c)) begin
            cand[k] = 1'b0;
          end
        end
        wlen = wlen + 8'd1;
      end
      if (c < CH_0 || c > CH_9) digits = 1'b0;
      if (c == CH_DOT) dot = 1'b1;
    endfunction

    // Classify the open word; the first full keyword match wins
    function void close_word();
      logic [4:0] kind;
      logic [1:0] variant;
      logic       found;
      kind = KIND_IDENT;
      variant = 2'd0;
      found = 1'b0;
      for (int k = 0; k < NUM_KW; k++) begin
        if (!found && cand[k] && !wovf && int'(wlen) == kw_text[k].len()) begin
          kind = kw_kind[k];
          variant = kw_var[k];
          found = 1'b1;
        end
      end
      if (!found) begin
        if (dot) kind = KIND_FLOAT;
        else if (digits) kind = KIND_INT;
      end
      push(kind, variant, wstart, wlen, wovf);
      restart_word();
    endfunction

    // Decode a byte that is not consumed by a pending operator
    function void take_fresh(logic [7:0] c);
      if (in_word) begin
        if (c == CH_SP || c == CH_SEMI || c == CH_COLON || c == CH_EQ ||
            c == CH_LT || c == CH_GT || c == CH_BANG) begin
          close_word();
        end else begin
          grow_word(c);
          return;
        end
      end
      case (c)
        CH_SP, CH_TAB, CH_CR, CH_LF: ;
        CH_COLON: push(KIND_COLON, 2'd0, pos, 8'd1, 1'b0);
        CH_GT:    push(KIND_GT, 2'd0, pos, 8'd1, 1'b0);
        CH_LT:    push(KIND_LT, 2'd0, pos, 8'd1, 1'b0);
        CH_SEMI:  push(KIND_SEMI, 2'd0, pos, 8'd1, 1'b0);
        CH_BANG: begin
          pend = PEND_BANG;
          wstart = pos;
        end
        CH_AMP: begin
          pend = PEND_AMP;
          wstart = pos;
        end
        CH_BAR: begin
          pend = PEND_BAR;
          wstart = pos;
        end
        CH_EQ: begin
          pend = PEND_EQ;
          wstart = pos;
        end
        default: begin
          restart_word();
          in_word = 1'b1;
          wstart = pos;
          grow_word(c);
        end
      endcase
    endfunction

    // Advance the state by one accepted byte and queue the tokens it completes
    function void take_byte(logic [7:0] c, logic eot);
      logic [2:0] p;
      logic       taken;
      p = pend;
      pend = PEND_NONE;
      taken = 1'b0;
      step_tokens.delete();
      if (p == PEND_BANG && c == CH_EQ) begin
        push(KIND_NOTEQ, 2'd0, wstart, 8'd2, 1'b0);
        taken = 1'b1;
      end else if (p == PEND_AMP && c == CH_AMP) begin
        push(KIND_AND, 2'd0, wstart, 8'd2, 1'b0);
        taken = 1'b1;
      end else if (p == PEND_BAR && c == CH_BAR) begin
        push(KIND_OR, 2'd0, wstart, 8'd2, 1'b0);
        taken = 1'b1;
      end else if (p == PEND_EQ) begin
        if (c == CH_EQ) begin
          push(KIND_EQEQ, 2'd0, wstart, 8'd2, 1'b0);
          taken = 1'b1;
        end else begin
          push(KIND_EQ, 2'd0, wstart, 8'd1, 1'b0);
        end
      end
      if (!taken) take_fresh(c);
      if (pos < MAX_POS) pos = pos + 16'd1;
      // Close the text: flush the word and a pending '=', restart positions
      if (eot) begin
        if (in_word) close_word();
        if (pend == PEND_EQ) push(KIND_EQ, 2'd0, wstart, 8'd1, 1'b0);
        pend = PEND_NONE;
        pos = '0;
      end
      if (step_tokens.size() > 0) step_tokens[$].last = 1'b1;
      foreach (step_tokens[i]) tokens_due.insert(tokens_due.size(), step_tokens[i]);
    endfunction

    function string show(token_t t);
      return $sformatf("kind %0d variant %0d start %0d length %0d too_long %0b last %0b",
                       t.kind, t.variant, t.start, t.length, t.too_long, t.last);
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= REPORT_MAX) $display("ERROR: %s", msg);
    endfunction

    // Compare an accepted token with the oldest one owed
    function void match_token(token_t got);
      token_t want;
      if (tokens_due.size() == 0) begin
        flag({"unexpected token: ", show(got)});
        return;
      end
      want = tokens_due.pop_front();
      if (got.kind !== want.kind || got.variant !== want.variant ||
          got.start !== want.start || got.length !== want.length ||
          got.too_long !== want.too_long || got.last !== want.last) begin
        flag({"token mismatch: expected ", show(want), "; got ", show(got)});
      end
    endfunction

    function void flag_missing();
      foreach (tokens_due[i]) flag({"token never seen: ", show(tokens_due[i])});
      tokens_due.delete();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] byte_in
  logic        in_tlast;   // end_of_text
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [15:0] text_start, [23:16] text_length
  logic [7:0]  out_tuser;  // [4:0] token_kind, [6:5] variant, [7] too_long
  logic        out_tlast;  // last_of_run

  token_tracker tracker;
  src_byte_t    source_text[$];
  int           token_bytes;
  int           cycles;
  token_t       seen;
  rx_mode_t     rx_mode;
  int           rx_left;

  control_language_tokenizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Stall the token side on a randomly chosen pattern that is redrawn when its run ends
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:     out_tready = 1'b1;
      RX_COIN:     out_tready = 1'($urandom_range(0, 1));
      RX_PERIODIC: out_tready = (cycles % 4 != 0);
      RX_STINGY:   out_tready = ($urandom_range(0, 9) == 0);
    endcase
  end

  // Check every token beat
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen.kind = out_tuser[4:0];
      seen.variant = out_tuser[6:5];
      seen.too_long = out_tuser[7];
      seen.start = out_tdata[15:0];
      seen.length = out_tdata[23:16];
      seen.last = out_tlast;
      tracker.match_token(seen);
    end
  end

  task automatic put_raw(logic [7:0] c);
    src_byte_t b;
    b.c = c;
    b.last = 1'b0;
    source_text.insert(source_text.size(), b);
  endtask

  task automatic put_byte(logic [7:0] c);
    put_raw(c);
    token_bytes++;
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic end_text();
    source_text[$].last = 1'b1;
  endtask

  // Emit one random token: keywords, near-keywords, numbers, names, operators, noise
  task automatic put_random_token();
    string alpha;
    string kw;
    string ops[12];
    int    n;
    alpha = "abcxyzQRS_09.&|\t";
    ops = '{":", "<", ">", ";", "!=", "&&", "||", "==", "=", "!", "&", "|"};
    kw = tracker.kw_text[$urandom_range(0, NUM_KW - 1)];
    case ($urandom_range(0, 11))
      0, 1, 2: put_text(kw);
      3: begin
        if ($urandom_range(0, 1)) put_text(kw.substr(0, kw.len() - 2));
        else put_text({kw, "X"});
      end
      4, 5: begin
        put_byte(alpha[$urandom_range(0, 8)]);
        repeat ($urandom_range(0, 7)) put_byte(alpha[$urandom_range(0, alpha.len() - 1)]);
      end
      6: repeat ($urandom_range(1, 6)) put_byte(8'(CH_0 + $urandom_range(0, 9)));
      7: begin
        repeat ($urandom_range(0, 3)) put_byte(8'(CH_0 + $urandom_range(0, 9)));
        put_byte(CH_DOT);
        repeat ($urandom_range(0, 3)) put_byte(8'(CH_0 + $urandom_range(0, 9)));
      end
      8, 9, 10: put_text(ops[$urandom_range(0, 11)]);
      default: begin
        n = $urandom_range(1, 3);
        repeat (n) put_byte(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  task automatic put_random_text();
    repeat ($urandom_range(1, 10)) begin
      put_random_token();
      case ($urandom_range(0, 5))
        0: ;
        1, 2: put_raw(CH_SP);
        3: put_raw(CH_TAB);
        4: begin
          put_raw(CH_CR);
          put_raw(CH_LF);
        end
        default: begin
          put_raw(CH_SP);
          put_raw(CH_SP);
        end
      endcase
    end
    end_text();
  endtask

  // Feed the queued bytes in bursts with random gaps
  task automatic send_text();
    src_byte_t b;
    int        burst_left;
    int        gap;
    burst_left = 0;
    while (source_text.size() > 0) begin
      b = source_text.pop_front();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_tvalid = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      burst_left--;
      in_tvalid = 1'b1;
      in_tdata = b.c;
      in_tlast = b.last;
      do @(posedge clk); while (!in_tready);
      tracker.take_byte(b.c, b.last);
      @(negedge clk);
    end
    in_tvalid = 1'b0;
    in_tlast = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cycles = 0;
    rx_left = 0;
    tracker = new();

    // Directed: every operator, lone operators, odd bytes inside a word, flush at end
    put_text(":<>;!=&&||===a !b&|\t");
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(CH_EQ);
    end_text();
    put_byte("x");
    end_text();
    put_byte(CH_AMP);
    end_text();

    // Word lengths at and past the limit; a dot after saturation still makes a float
    repeat (255) put_byte("z");
    put_byte(CH_SP);
    put_text("VAR");
    repeat (254) put_byte("7");
    put_byte(CH_DOT);
    put_byte(CH_SEMI);
    end_text();
    put_text("END_IF");
    end_text();

    // Random texts
    token_bytes = 0;
    while (token_bytes < RANDOM_BYTES) put_random_text();

    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    send_text();

    while (tracker.tokens_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    tracker.flag_missing();
    if (tracker.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
